/* rtl/plc_timer_bank_prescaled_assert.svh */
// Assertion macros used by the checker of the timer bank.
`ifndef PLC_TIMER_BANK_PRESCALED_ASSERT_SVH
`define PLC_TIMER_BANK_PRESCALED_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ptb_pkg.sv */
package ptb_pkg;

  localparam int BANK_STRIDE = 16;
  localparam int STORE_DEPTH = 48;
  localparam int SLOT_W = 6;
  localparam int IDX_W = 4;
  localparam int TIMER_W = 15;
  localparam int ENABLE_W = 16;
  localparam int COUNT_W = 32;
  localparam int DEF_TIMERS_PER_BANK = 16;

  localparam logic [TIMER_W-1:0] TIMER_MAX = 15'h7FFF;

  localparam int PERIOD_10 = 10;
  localparam int PERIOD_100 = 100;
  localparam int PERIOD_200 = 200;
  localparam int PERIOD_500 = 500;
  localparam int PERIOD_1000 = 1000;
  localparam int PERIOD_60000 = 60000;

  localparam int P10_W = $clog2(PERIOD_10);
  localparam int P100_W = $clog2(PERIOD_100);
  localparam int P200_W = $clog2(PERIOD_200);
  localparam int P500_W = $clog2(PERIOD_500);
  localparam int P1000_W = $clog2(PERIOD_1000);
  localparam int P60000_W = $clog2(PERIOD_60000);

  localparam int STROBE_COUNT = 6;
  localparam int STB_10 = 0;
  localparam int STB_100 = 1;
  localparam int STB_200 = 2;
  localparam int STB_500 = 3;
  localparam int STB_1000 = 4;
  localparam int STB_60000 = 5;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] BANK_FAST = 2'd0;
  localparam logic [1:0] BANK_MID = 2'd1;
  localparam logic [1:0] BANK_SLOW = 2'd2;

  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  addr;
    logic [TIMER_W-1:0] data;
  } ptb_wr_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } ptb_rd_t;

endpackage

/* rtl/plc_timer_bank_prescaled.sv */
// Timer bank of 48 slots: a 1 ms, a 10 ms and a 100 ms bank of timers.
// Requests enter on req_valid/req_ready. A tick request (opcode 0) steps
// the six prescalers and the tick count, then walks all 48 slots through
// one shared saturating incrementer, one slot per cycle, pipelined over the
// registered read port of the timer memory. Enabled timers count up to
// 32767, disabled ones are cleared; the 10 ms and 100 ms banks only change
// on ticks that raise strobe_10 or strobe_100. A read request (opcode 1)
// returns the value of the timer named by read_slot.
// A tick passes through S_WALK and a read through S_READ; both then reach
// S_DONE, where the response is registered. The slot walk over the single
// memory port sets the length of a tick.
// One response is given for every request on rsp_valid/rsp_ready. The
// response register holds while the receiver stalls; a finished result then
// waits in S_DONE and no request is accepted until the response is taken.
// Reset clears the timers, the prescalers and the tick count at once.
module plc_timer_bank_prescaled #(
  parameter int TIMERS_PER_BANK = ptb_pkg::DEF_TIMERS_PER_BANK
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic                           opcode,
  input  logic [ptb_pkg::ENABLE_W-1:0]   enables_fast,
  input  logic [ptb_pkg::ENABLE_W-1:0]   enables_mid,
  input  logic [ptb_pkg::ENABLE_W-1:0]   enables_slow,
  input  logic [ptb_pkg::SLOT_W-1:0]     read_slot,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [ptb_pkg::TIMER_W-1:0]    timer_value,
  output logic                           strobe_10,
  output logic                           strobe_100,
  output logic                           strobe_200,
  output logic                           strobe_500,
  output logic                           strobe_1000,
  output logic                           strobe_60000,
  output logic [ptb_pkg::COUNT_W-1:0]    tick_total
);
  import ptb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  logic   accept;

  logic                    op;
  logic [ENABLE_W-1:0]     en_fast;
  logic [ENABLE_W-1:0]     en_mid;
  logic [ENABLE_W-1:0]     en_slow;
  logic [SLOT_W-1:0]       slot;
  logic [STROBE_COUNT-1:0] stb;
  logic [STROBE_COUNT-1:0] stb_next;

  logic [P10_W-1:0]    p10;
  logic [P100_W-1:0]   p100;
  logic [P200_W-1:0]   p200;
  logic [P500_W-1:0]   p500;
  logic [P1000_W-1:0]  p1000;
  logic [P60000_W-1:0] p60000;
  logic [COUNT_W-1:0]  tick_count;

  logic [SLOT_W-1:0] walk_addr;
  logic              wb_vld;
  logic [SLOT_W-1:0] wb_addr;
  logic [IDX_W-1:0]  wb_idx;
  logic [1:0]        wb_bank;
  logic              wb_upd;
  logic              wb_en_bit;

  logic              rd_ok;
  ptb_wr_t           wr;
  ptb_rd_t           rd;
  logic [TIMER_W-1:0] rd_data;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == S_IDLE);

  assign stb_next[STB_10]    = (p10 == P10_W'(PERIOD_10 - 1));
  assign stb_next[STB_100]   = (p100 == P100_W'(PERIOD_100 - 1));
  assign stb_next[STB_200]   = (p200 == P200_W'(PERIOD_200 - 1));
  assign stb_next[STB_500]   = (p500 == P500_W'(PERIOD_500 - 1));
  assign stb_next[STB_1000]  = (p1000 == P1000_W'(PERIOD_1000 - 1));
  assign stb_next[STB_60000] = (p60000 == P60000_W'(PERIOD_60000 - 1));

  // Slots past the store and indices past the bank size name no timer.
  assign rd_ok = (slot < SLOT_W'(STORE_DEPTH)) &&
                 ({1'b0, slot[IDX_W-1:0]} < (IDX_W + 1)'(TIMERS_PER_BANK));

  assign wb_idx  = wb_addr[IDX_W-1:0];
  assign wb_bank = wb_addr[SLOT_W-1:IDX_W];

  always_comb begin
    wb_upd    = 1'b0;
    wb_en_bit = 1'b0;
    case (wb_bank)
      BANK_FAST: begin
        wb_upd    = 1'b1;
        wb_en_bit = en_fast[wb_idx];
      end
      BANK_MID: begin
        wb_upd    = stb[STB_10];
        wb_en_bit = en_mid[wb_idx];
      end
      BANK_SLOW: begin
        wb_upd    = stb[STB_100];
        wb_en_bit = en_slow[wb_idx];
      end
      default: begin
        wb_upd    = 1'b0;
        wb_en_bit = 1'b0;
      end
    endcase
    if ({1'b0, wb_idx} >= (IDX_W + 1)'(TIMERS_PER_BANK)) begin
      wb_upd = 1'b0;
    end
  end

  always_comb begin
    wr.en   = wb_vld && wb_upd;
    wr.addr = wb_addr;
    if (!wb_en_bit) begin
      wr.data = '0;
    end else if (rd_data == TIMER_MAX) begin
      wr.data = rd_data;
    end else begin
      wr.data = rd_data + 1'b1;
    end
  end

  always_comb begin
    rd.en   = 1'b0;
    rd.addr = walk_addr;
    case (state)
      S_WALK: begin
        rd.en = 1'b1;
      end
      S_READ: begin
        rd.en   = rd_ok;
        rd.addr = slot;
      end
      default: begin
        rd.en = 1'b0;
      end
    endcase
  end

  ptb_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= opcode;
      en_fast <= enables_fast;
      en_mid  <= enables_mid;
      en_slow <= enables_slow;
      slot    <= read_slot;
      stb     <= (opcode == OP_TICK) ? stb_next : '0;
    end
    if (state == S_WALK) begin
      wb_addr <= walk_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      walk_addr  <= '0;
      wb_vld     <= 1'b0;
      p10        <= '0;
      p100       <= '0;
      p200       <= '0;
      p500       <= '0;
      p1000      <= '0;
      p60000     <= '0;
      tick_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      wb_vld <= (state == S_WALK);
      if ((state == S_DONE) && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (opcode == OP_TICK)) begin
            p10        <= stb_next[STB_10] ? '0 : p10 + 1'b1;
            p100       <= stb_next[STB_100] ? '0 : p100 + 1'b1;
            p200       <= stb_next[STB_200] ? '0 : p200 + 1'b1;
            p500       <= stb_next[STB_500] ? '0 : p500 + 1'b1;
            p1000      <= stb_next[STB_1000] ? '0 : p1000 + 1'b1;
            p60000     <= stb_next[STB_60000] ? '0 : p60000 + 1'b1;
            tick_count <= tick_count + 1'b1;
            walk_addr  <= '0;
            state      <= S_WALK;
          end else if (accept) begin
            state <= S_READ;
          end
        end
        S_WALK: begin
          walk_addr <= walk_addr + 1'b1;
          if (walk_addr == SLOT_W'(STORE_DEPTH - 1)) begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!rsp_valid || rsp_ready)) begin
      timer_value  <= ((op == OP_READ) && rd_ok) ? rd_data : '0;
      strobe_10    <= stb[STB_10];
      strobe_100   <= stb[STB_100];
      strobe_200   <= stb[STB_200];
      strobe_500   <= stb[STB_500];
      strobe_1000  <= stb[STB_1000];
      strobe_60000 <= stb[STB_60000];
      tick_total   <= tick_count;
    end
  end

endmodule

/* rtl/ptb_store.sv */
module ptb_store (
  input  logic                          clk,
  input  logic                          rst,
  input  ptb_pkg::ptb_wr_t              wr,
  input  ptb_pkg::ptb_rd_t              rd,
  output logic [ptb_pkg::TIMER_W-1:0]   rd_data
);
  import ptb_pkg::*;

  logic [TIMER_W-1:0]     mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld;
  logic [TIMER_W-1:0]     mem_q;
  logic                   vld_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      mem_q <= mem[rd.addr];
    end
  end

  // An entry that has never been written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        vld_q <= vld[rd.addr];
      end
    end
  end

  assign rd_data = vld_q ? mem_q : '0;

endmodule

/* rtl/ptb_check.sv */
`include "plc_timer_bank_prescaled_assert.svh"

module ptb_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [ptb_pkg::TIMER_W-1:0]  timer_value,
  input logic                         strobe_10,
  input logic                         strobe_100,
  input logic                         strobe_200,
  input logic                         strobe_500,
  input logic                         strobe_1000,
  input logic                         strobe_60000,
  input logic [ptb_pkg::COUNT_W-1:0]  tick_total
);

  // A response that carries a timer value comes from a read and has no strobes.
  `PTB_ASSERT_SAME(a_read_no_strobe, rsp_valid && (timer_value != '0), !strobe_10 && !strobe_100 && !strobe_200 && !strobe_500 && !strobe_1000 && !strobe_60000, "Read response carries a strobe.")

  // Each checked period is a multiple of the shorter ones it names, so their strobes coincide.
  `PTB_ASSERT_SAME(a_strobe_nest, rsp_valid && strobe_1000, strobe_10 && strobe_100 && strobe_200 && strobe_500, "Strobe of 1000 without its divisors.")

  `PTB_ASSERT_SAME(a_strobe_minute, rsp_valid && strobe_60000, strobe_1000 && strobe_100 && strobe_10, "Strobe of 60000 without its divisors.")

  // The block works on one request at a time.
  `PTB_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "Ready straight after an accepted request.")

  `PTB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(tick_total) && $stable(timer_value), "Stalled response changed.")

endmodule

bind plc_timer_bank_prescaled ptb_check u_check (.*);

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import ptb_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int DIRECTED_ROWS = 24;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PERIODS [STROBE_COUNT] = '{PERIOD_10, PERIOD_100, PERIOD_200,
                                            PERIOD_500, PERIOD_1000, PERIOD_60000};

  typedef struct packed {
    logic [TIMER_W-1:0]      value;
    logic [STROBE_COUNT-1:0] strobes;
    logic [COUNT_W-1:0]      total;
  } timer_reading_t;

  typedef struct packed {
    logic                op;
    logic [ENABLE_W-1:0] fast;
    logic [ENABLE_W-1:0] mid;
    logic [ENABLE_W-1:0] slow;
    logic [SLOT_W-1:0]   slot;
    logic                typed;
    logic [TIMER_W-1:0]  value;
    logic [COUNT_W-1:0]  total;
  } request_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  logic                opcode = OP_TICK;
  logic [ENABLE_W-1:0] enables_fast = '0;
  logic [ENABLE_W-1:0] enables_mid = '0;
  logic [ENABLE_W-1:0] enables_slow = '0;
  logic [SLOT_W-1:0]   read_slot = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  logic [TIMER_W-1:0]  timer_value;
  logic                strobe_10;
  logic                strobe_100;
  logic                strobe_200;
  logic                strobe_500;
  logic                strobe_1000;
  logic                strobe_60000;
  logic [COUNT_W-1:0]  tick_total;

  wire [STROBE_COUNT-1:0] strobes_seen = {strobe_60000, strobe_1000, strobe_500,
                                          strobe_200, strobe_100, strobe_10};

  logic [TIMER_W-1:0] timer_copy [STORE_DEPTH];
  int                 prescale_copy [STROBE_COUNT];
  logic [COUNT_W-1:0] tick_copy;

  timer_reading_t pending_readings [$];
  int             fails = 0;
  int             quiet_cycles = 0;
  int             send_idle = 0;
  int             recv_stall = 0;

  logic [ENABLE_W-1:0] mask_fast = '0;
  logic [ENABLE_W-1:0] mask_mid = '0;
  logic [ENABLE_W-1:0] mask_slow = '0;

  request_row_t plan [DIRECTED_ROWS] = '{
    '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b1, 15'd0, 32'd0},
    '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd47, 1'b1, 15'd0, 32'd0},
    '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd48, 1'b1, 15'd0, 32'd0},
    '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd63, 1'b1, 15'd0, 32'd0},
    '{OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63, 1'b1, 15'd0, 32'd1},
    '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b1, 15'd1, 32'd1},
    '{OP_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd15, 1'b1, 15'd1, 32'd1},
    '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd16, 1'b1, 15'd0, 32'd1},
    '{OP_TICK, 16'h0000, 16'hFFFF, 16'hFFFF, 6'd0,  1'b1, 15'd0, 32'd2},
    '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b1, 15'd0, 32'd2},
    '{OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0,  1'b0, 15'd0, 32'd0},
    '{OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0,  1'b0, 15'd0, 32'd0},
    '{OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0,  1'b0, 15'd0, 32'd0},
    '{OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0,  1'b0, 15'd0, 32'd0},
    '{OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0,  1'b0, 15'd0, 32'd0},
    '{OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0,  1'b0, 15'd0, 32'd0},
    '{OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0,  1'b0, 15'd0, 32'd0},
    '{OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0,  1'b0, 15'd0, 32'd0},
    '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd16, 1'b0, 15'd0, 32'd0},
    '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd31, 1'b0, 15'd0, 32'd0},
    '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd32, 1'b0, 15'd0, 32'd0},
    '{OP_TICK, 16'h5555, 16'hAAAA, 16'h0000, 6'd5,  1'b0, 15'd0, 32'd0},
    '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd0,  1'b0, 15'd0, 32'd0},
    '{OP_READ, 16'h0000, 16'h0000, 16'h0000, 6'd1,  1'b0, 15'd0, 32'd0}
  };

  plc_timer_bank_prescaled uut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .opcode       (opcode),
    .enables_fast (enables_fast),
    .enables_mid  (enables_mid),
    .enables_slow (enables_slow),
    .read_slot    (read_slot),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .timer_value  (timer_value),
    .strobe_10    (strobe_10),
    .strobe_100   (strobe_100),
    .strobe_200   (strobe_200),
    .strobe_500   (strobe_500),
    .strobe_1000  (strobe_1000),
    .strobe_60000 (strobe_60000),
    .tick_total   (tick_total)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    foreach (timer_copy[i]) timer_copy[i] = '0;
    foreach (prescale_copy[k]) prescale_copy[k] = 0;
    tick_copy = '0;
  end

  function automatic void step_bank(input logic [1:0] bank, input logic [ENABLE_W-1:0] en);
    int slot;
    for (int n = 0; n < DEF_TIMERS_PER_BANK && n < BANK_STRIDE; n++) begin
      slot = bank * BANK_STRIDE + n;
      if (en[n]) begin
        if (timer_copy[slot] != TIMER_MAX) timer_copy[slot] = timer_copy[slot] + 1'b1;
      end else begin
        timer_copy[slot] = '0;
      end
    end
  endfunction

  function automatic timer_reading_t advance_timer_bank(
    input logic op, input logic [ENABLE_W-1:0] fast, input logic [ENABLE_W-1:0] mid,
    input logic [ENABLE_W-1:0] slow, input logic [SLOT_W-1:0] slot);
    timer_reading_t reading;
    reading = '0;
    if (op == OP_TICK) begin
      for (int k = 0; k < STROBE_COUNT; k++) begin
        prescale_copy[k] = prescale_copy[k] + 1;
        if (prescale_copy[k] >= PERIODS[k]) begin
          reading.strobes[k] = 1'b1;
          prescale_copy[k] = 0;
        end
      end
      step_bank(BANK_FAST, fast);
      if (reading.strobes[STB_10]) step_bank(BANK_MID, mid);
      if (reading.strobes[STB_100]) step_bank(BANK_SLOW, slow);
      tick_copy = tick_copy + 1'b1;
    end else if (slot < STORE_DEPTH && (slot % BANK_STRIDE) < DEF_TIMERS_PER_BANK) begin
      reading.value = timer_copy[slot];
    end
    reading.total = tick_copy;
    return reading;
  endfunction

  function automatic logic [ENABLE_W-1:0] drift_mask(input logic [ENABLE_W-1:0] m);
    int pick;
    pick = $urandom_range(99);
    if (pick < 1) return '0;
    if (pick < 2) return '1;
    if (pick < 4) return ENABLE_W'($urandom);
    if (pick < 14) return m ^ (ENABLE_W'(1) << $urandom_range(ENABLE_W - 1));
    return m;
  endfunction

  task automatic issue_request(
    input logic op, input logic [ENABLE_W-1:0] fast, input logic [ENABLE_W-1:0] mid,
    input logic [ENABLE_W-1:0] slow, input logic [SLOT_W-1:0] slot, input logic typed,
    input logic [TIMER_W-1:0] value, input logic [COUNT_W-1:0] total);
    timer_reading_t reading;
    req_valid <= 1'b1;
    opcode <= op;
    enables_fast <= fast;
    enables_mid <= mid;
    enables_slow <= slow;
    read_slot <= slot;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    reading = advance_timer_bank(op, fast, mid, slow, slot);
    if (typed) begin
      reading.value = value;
      reading.strobes = '0;
      reading.total = total;
    end
    pending_readings.push_back(reading);
  endtask

  task automatic hold_off();
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin : stimulus
    request_row_t row;
    logic         op;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i]) begin
      row = plan[i];
      issue_request(row.op, row.fast, row.mid, row.slow, row.slot, row.typed,
                    row.value, row.total);
      hold_off();
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case (n * 4 / RANDOM_ITEMS)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 67; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 67; end
        default: begin send_idle = 20; recv_stall = 20; end
      endcase
      op = ($urandom_range(99) < 70) ? OP_TICK : OP_READ;
      if (op == OP_TICK) begin
        mask_fast = drift_mask(mask_fast);
        mask_mid = drift_mask(mask_mid);
        mask_slow = drift_mask(mask_slow);
        issue_request(op, mask_fast, mask_mid, mask_slow, SLOT_W'($urandom_range(63)),
                      1'b0, '0, '0);
      end else begin
        issue_request(op, ENABLE_W'($urandom), ENABLE_W'($urandom), ENABLE_W'($urandom),
                      ($urandom_range(99) < 85) ? SLOT_W'($urandom_range(STORE_DEPTH - 1))
                                                : SLOT_W'($urandom_range(63)),
                      1'b0, '0, '0);
      end
      hold_off();
    end
    req_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin : response_check
    timer_reading_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_readings.size() == 0) begin
        $error("response with no request outstanding");
        fails++;
      end else begin
        want = pending_readings.pop_front();
        if (timer_value !== want.value) begin
          $error("timer_value expected %0d got %0d", want.value, timer_value);
          fails++;
        end
        for (int k = 0; k < STROBE_COUNT; k++) begin
          if (strobes_seen[k] !== want.strobes[k]) begin
            $error("strobe_%0d expected %0b got %0b", PERIODS[k], want.strobes[k],
                   strobes_seen[k]);
            fails++;
          end
        end
        if (tick_total !== want.total) begin
          $error("tick_total expected %0d got %0d", want.total, tick_total);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ptb_pkg.sv
rtl/ptb_store.sv
rtl/plc_timer_bank_prescaled.sv
rtl/ptb_check.sv
bench/testbench.sv
